>>> rtl/core/lbd_pkg.sv
`default_nettype none

package lbd_pkg;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_GRAD = 1'b1;

    localparam logic CFG_IN_DIM  = 1'b0;
    localparam logic CFG_OUT_DIM = 1'b1;

    localparam int IN_DIM_W  = 7;
    localparam int OUT_DIM_W = 9;
    localparam int CFG_W     = 9;
    localparam int ROW_W     = 6;
    localparam int COL_W     = 8;
    localparam int VAL_W     = 32;
    localparam int S_DATA_W  = 48;
    localparam int M_DATA_W  = 40;

    localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
    localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;

    localparam logic [IN_DIM_W-1:0]  IN_DIM_RST  = 7'd64;
    localparam logic [OUT_DIM_W-1:0] OUT_DIM_RST = 9'd256;

    typedef struct packed {
        logic accept;
        logic issue;
        logic drain;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic in_op;
        logic in_upd_ok;
        logic in_last;
        logic pipe_busy;
        logic out_full;
    } t_sts;

endpackage

`default_nettype wire

>>> rtl/core/lbd_fma.sv
`default_nettype none

module lbd_fma #(
    parameter int TW = 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [TW-1:0] i_tag,
    input  wire logic [31:0]   i_a,
    input  wire logic [31:0]   i_b,
    input  wire logic [31:0]   i_c,
    output logic               o_valid,
    output logic [TW-1:0]      o_tag,
    output logic [31:0]        o_res,
    output logic               o_busy
);

    localparam logic [31:0] FP_QNAN_L = lbd_pkg::FP_QNAN;

    logic [5:0]    r_v;
    logic [TW-1:0] r_tag [6];
    logic [31:0]   r_spv [5];
    logic [4:0]    r_spec;

    // stage 1: unpack, specials, mantissa product
    logic [7:0]  ea, eb, ec;
    logic [22:0] fa, fb, fc;
    logic        nan_in, inf_a, inf_b, inf_c, zero_a, zero_b, zero_c, sp, nan_all;
    logic [31:0] n_spv;
    logic        n_spec;

    assign ea = i_a[30:23];
    assign eb = i_b[30:23];
    assign ec = i_c[30:23];
    assign fa = i_a[22:0];
    assign fb = i_b[22:0];
    assign fc = i_c[22:0];
    assign inf_a  = (ea == 8'hFF) && (fa == 23'd0);
    assign inf_b  = (eb == 8'hFF) && (fb == 23'd0);
    assign inf_c  = (ec == 8'hFF) && (fc == 23'd0);
    assign zero_a = (ea == 8'd0) && (fa == 23'd0);
    assign zero_b = (eb == 8'd0) && (fb == 23'd0);
    assign zero_c = (ec == 8'd0) && (fc == 23'd0);
    assign nan_in = ((ea == 8'hFF) && (fa != 23'd0)) || ((eb == 8'hFF) && (fb != 23'd0))
                 || ((ec == 8'hFF) && (fc != 23'd0));
    assign sp = i_a[31] ^ i_b[31];
    assign nan_all = nan_in || (inf_a && zero_b) || (zero_a && inf_b)
                  || ((inf_a || inf_b) && inf_c && (sp != i_c[31]));

    always_comb begin
        n_spec = 1'b1;
        n_spv  = FP_QNAN_L;
        if (nan_all) begin
            n_spv = FP_QNAN_L;
        end else if (inf_a || inf_b) begin
            n_spv = {sp, 8'hFF, 23'd0};
        end else if (inf_c) begin
            n_spv = i_c;
        end else if ((zero_a || zero_b) && zero_c) begin
            n_spv = {sp & i_c[31], 31'd0};
        end else begin
            n_spec = 1'b0;
        end
    end

    logic [47:0]        r1_pm;
    logic signed [11:0] r1_ep, r1_ec;
    logic [23:0]        r1_cm;
    logic               r1_sp, r1_sc, r1_zp, r1_zc;

    always_ff @(posedge i_clk) begin
        r1_pm <= {ea != 8'd0, fa} * {eb != 8'd0, fb};
        r1_ep <= $signed({4'd0, (ea == 8'd0) ? 8'd1 : ea})
               + $signed({4'd0, (eb == 8'd0) ? 8'd1 : eb}) - 12'sd127;
        r1_ec <= $signed({4'd0, (ec == 8'd0) ? 8'd1 : ec});
        r1_cm <= {ec != 8'd0, fc};
        r1_sp <= sp;
        r1_sc <= i_c[31];
        r1_zp <= zero_a || zero_b;
        r1_zc <= zero_c;
        r_spv[0]  <= n_spv;
        r_spec[0] <= n_spec;
        r_tag[0]  <= i_tag;
    end

    // stage 2: align the smaller operand
    logic [47:0]        big, smaller, c48;
    logic signed [11:0] d, sh, eb_big;
    logic               s_big, s_small;
    logic [6:0]         shc;
    logic [151:0]       wide2;
    logic [75:0]        small_al;

    assign c48 = {r1_cm, 23'd0};
    assign d   = r1_ep - r1_ec;

    always_comb begin
        big     = r1_pm;
        smaller = 48'd0;
        eb_big  = r1_ep;
        s_big   = r1_sp;
        s_small = r1_sc;
        sh      = 12'sd0;
        if (r1_zp) begin
            big    = c48;
            eb_big = r1_ec;
            s_big  = r1_sc;
        end else if (r1_zc) begin
            big = r1_pm;
        end else if (d >= 12'sd0) begin
            smaller = c48;
            sh      = d;
        end else begin
            big     = c48;
            eb_big  = r1_ec;
            s_big   = r1_sc;
            smaller = r1_pm;
            s_small = r1_sp;
            sh      = -d;
        end
        shc      = (sh > 12'sd76) ? 7'd76 : 7'(sh);
        wide2    = {2'd0, smaller, 26'd0, 76'd0} >> shc;
        small_al = {wide2[151:77], wide2[76] | (|wide2[75:0])};
    end

    logic [75:0]        r2_big, r2_small;
    logic signed [11:0] r2_eb;
    logic               r2_s, r2_sub;

    always_ff @(posedge i_clk) begin
        r2_big    <= {2'd0, big, 26'd0};
        r2_small  <= small_al;
        r2_eb     <= eb_big;
        r2_s      <= s_big;
        r2_sub    <= s_big != s_small;
        r_spv[1]  <= r_spv[0];
        r_spec[1] <= r_spec[0];
        r_tag[1]  <= r_tag[0];
    end

    // stage 3: add or subtract magnitudes
    logic [76:0] diff;
    logic [75:0] mag3;
    logic        sgn3;

    always_comb begin
        diff = {1'b0, r2_big} - {1'b0, r2_small};
        if (r2_sub) begin
            mag3 = diff[76] ? (~diff[75:0]) + 76'd1 : diff[75:0];
            sgn3 = r2_s ^ diff[76];
        end else begin
            mag3 = r2_big + r2_small;
            sgn3 = r2_s;
        end
    end

    logic [75:0]        r3_mag;
    logic signed [11:0] r3_eb;
    logic               r3_s;

    always_ff @(posedge i_clk) begin
        r3_mag    <= mag3;
        r3_eb     <= r2_eb;
        r3_s      <= sgn3;
        r_spv[2]  <= r_spv[1];
        r_spec[2] <= r_spec[1];
        r_tag[2]  <= r_tag[1];
    end

    // stage 4: leading zero count
    logic [6:0] lz;

    always_comb begin
        lz = 7'd76;
        for (int k = 0; k < 76; k++) begin
            if (r3_mag[k]) begin
                lz = 7'(75 - k);
            end
        end
    end

    logic [75:0]        r4_mag;
    logic [6:0]         r4_lz;
    logic signed [11:0] r4_eb;
    logic               r4_s, r4_zero;

    always_ff @(posedge i_clk) begin
        r4_mag    <= r3_mag;
        r4_lz     <= lz;
        r4_eb     <= r3_eb;
        r4_s      <= r3_s;
        r4_zero   <= r3_mag == 76'd0;
        r_spv[3]  <= r_spv[2];
        r_spec[3] <= r_spec[2];
        r_tag[3]  <= r_tag[2];
    end

    // stage 5: normalise, or denormalise below the smallest exponent
    logic signed [11:0] lim, lsh, rsh, expf;
    logic [6:0]         rshc;
    logic [151:0]       wide5;
    logic [75:0]        norm;
    logic               st5;

    always_comb begin
        lim   = r4_eb + 12'sd2;
        lsh   = ($signed({5'd0, r4_lz}) <= lim) ? $signed({5'd0, r4_lz}) : lim;
        rsh   = -lsh;
        rshc  = (rsh > 12'sd76) ? 7'd76 : 7'(rsh);
        wide5 = {r4_mag, 76'd0} >> rshc;
        if (lsh >= 12'sd0) begin
            norm = r4_mag << lsh[6:0];
            st5  = 1'b0;
        end else begin
            norm = wide5[151:76];
            st5  = |wide5[75:0];
        end
        expf = norm[75] ? (r4_eb + 12'sd3 - lsh) : 12'sd0;
    end

    logic [75:0]        r5_norm;
    logic signed [11:0] r5_exp;
    logic               r5_st, r5_s, r5_zero;

    always_ff @(posedge i_clk) begin
        r5_norm   <= norm;
        r5_exp    <= expf;
        r5_st     <= st5;
        r5_s      <= r4_s;
        r5_zero   <= r4_zero;
        r_spv[4]  <= r_spv[3];
        r_spec[4] <= r_spec[3];
        r_tag[4]  <= r_tag[3];
    end

    // stage 6: round to nearest even and pack
    logic [30:0] rnd;
    logic        rinc;
    logic [31:0] res6;

    always_comb begin
        rinc = r5_norm[51] && (r5_st || (|r5_norm[50:0]) || r5_norm[52]);
        rnd  = {r5_exp[7:0], r5_norm[74:52]} + {30'd0, rinc};
        if (r_spec[4]) begin
            res6 = r_spv[4];
        end else if (r5_zero) begin
            res6 = 32'd0;
        end else if (r5_exp >= 12'sd255) begin
            res6 = {r5_s, 8'hFF, 23'd0};
        end else begin
            res6 = {r5_s, rnd};
        end
    end

    always_ff @(posedge i_clk) begin
        o_res    <= res6;
        r_tag[5] <= r_tag[4];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    assign o_valid = r_v[5];
    assign o_tag   = r_tag[5];
    assign o_busy  = |r_v;

endmodule

`default_nettype wire

>>> rtl/core/lbd_ctrl.sv
`default_nettype none

module lbd_ctrl #(
    parameter int MAX_IN = 64,
    localparam int IW = (MAX_IN > 1) ? $clog2(MAX_IN) : 1,
    localparam int NW = $clog2(MAX_IN + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_tvalid,
    output logic                      o_tready,
    input  wire lbd_pkg::t_sts        i_sts,
    input  wire logic [NW-1:0]        i_n,
    output lbd_pkg::t_cmd             o_cmd,
    output logic [IW-1:0]             o_idx
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UPD  = 3'd1;
    localparam logic [2:0] ST_UPW  = 3'd2;
    localparam logic [2:0] ST_DRN  = 3'd3;
    localparam logic [2:0] ST_DRW  = 3'd4;
    localparam logic [2:0] ST_CLR  = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_last, n_last;
    logic          idx_end, accept;

    assign idx_end  = ((NW + 1)'(r_idx) + (NW + 1)'(1)) == (NW + 1)'(i_n);
    assign o_tready = r_state == ST_IDLE;
    assign accept   = i_tvalid && o_tready;
    assign o_idx    = r_idx;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_last       = r_last;
        o_cmd        = '0;
        o_cmd.accept = accept;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_sts.in_op == lbd_pkg::OP_GRAD)) begin
                    n_idx  = '0;
                    n_last = i_sts.in_last;
                    if (i_sts.in_upd_ok) begin
                        n_state = ST_UPD;
                    end else if (i_sts.in_last) begin
                        n_state = (i_n != '0) ? ST_DRN : ST_CLR;
                    end
                end
            end
            ST_UPD: begin
                o_cmd.issue = 1'b1;
                if (idx_end) begin
                    n_state = ST_UPW;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            ST_UPW: begin
                if (!i_sts.pipe_busy) begin
                    n_idx   = '0;
                    n_state = r_last ? ST_DRN : ST_IDLE;
                end
            end
            ST_DRN: begin
                if (!i_sts.pipe_busy && !i_sts.out_full) begin
                    o_cmd.issue = 1'b1;
                    o_cmd.drain = 1'b1;
                    n_state     = ST_DRW;
                end
            end
            ST_DRW: begin
                if (!i_sts.pipe_busy) begin
                    if (idx_end) begin
                        n_state = ST_CLR;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = ST_DRN;
                    end
                end
            end
            ST_CLR: begin
                o_cmd.clear = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_last  <= n_last;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lbd_datapath.sv
`default_nettype none

module lbd_datapath #(
    parameter int MAX_IN  = 64,
    parameter int MAX_OUT = 256,
    localparam int IW = (MAX_IN > 1) ? $clog2(MAX_IN) : 1,
    localparam int NW = $clog2(MAX_IN + 1)
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire lbd_pkg::t_cmd                   i_cmd,
    input  wire logic [IW-1:0]                   i_idx,
    output lbd_pkg::t_sts                        o_sts,
    output logic [NW-1:0]                        o_n,
    input  wire logic [lbd_pkg::S_DATA_W-1:0]    i_tdata,
    input  wire logic                            i_tuser,
    input  wire logic                            i_tlast,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic                            i_cfg_index,
    input  wire logic [lbd_pkg::CFG_W-1:0]       i_cfg_data,
    output logic                                 o_tvalid,
    input  wire logic                            i_tready,
    output logic [lbd_pkg::M_DATA_W-1:0]         o_tdata,
    output logic                                 o_tlast
);

    localparam int DEPTH = MAX_IN * MAX_OUT;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = IW + 1;

    logic [lbd_pkg::IN_DIM_W-1:0]  r_in_dim;
    logic [lbd_pkg::OUT_DIM_W-1:0] r_out_dim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_dim  <= lbd_pkg::IN_DIM_RST;
            r_out_dim <= lbd_pkg::OUT_DIM_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lbd_pkg::CFG_IN_DIM:  r_in_dim  <= i_cfg_data[lbd_pkg::IN_DIM_W-1:0];
                lbd_pkg::CFG_OUT_DIM: r_out_dim <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    logic [lbd_pkg::ROW_W-1:0] in_row;
    logic [lbd_pkg::COL_W-1:0] in_col;
    logic [lbd_pkg::VAL_W-1:0] in_val;
    logic                      col_ok, row_ok, w_en;
    logic [NW-1:0]             n;

    assign in_row = i_tdata[5:0];
    assign in_col = i_tdata[13:6];
    assign in_val = i_tdata[45:14];
    assign col_ok = ({1'b0, in_col} < r_out_dim) && (int'(in_col) < MAX_OUT);
    assign row_ok = int'(in_row) < MAX_IN;
    assign n      = (int'(r_in_dim) > MAX_IN) ? NW'(MAX_IN) : NW'(r_in_dim);
    assign o_n    = n;
    assign w_en   = i_cmd.accept && (i_tuser == lbd_pkg::OP_LOAD) && col_ok && row_ok;

    logic [31:0]               r_val;
    logic [lbd_pkg::COL_W-1:0] r_col;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_val <= in_val;
            r_col <= in_col;
        end
    end

    logic [31:0]   wmem [DEPTH];
    logic [31:0]   r_wq;
    logic [AW-1:0] w_addr, rd_addr;

    assign w_addr  = AW'(int'(in_row) * MAX_OUT + int'(in_col));
    assign rd_addr = AW'(int'(i_idx) * MAX_OUT + int'(r_col));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            wmem[w_addr] <= in_val;
        end
        if (i_cmd.issue) begin
            r_wq <= wmem[rd_addr];
        end
    end

    logic [31:0]       ev_mem [MAX_IN];
    logic [31:0]       od_mem [MAX_IN];
    logic [MAX_IN-1:0] r_ev_vld, r_od_vld;
    logic [31:0]       r_ev_q, r_od_q;
    logic              r_ev_ok, r_od_ok;
    logic              r_rd_valid, r_rd_drain;
    logic [IW-1:0]     r_rd_idx;

    logic          f_valid;
    logic [TW-1:0] f_tag;
    logic [31:0]   f_res;
    logic          f_busy;
    logic [IW-1:0] f_idx;
    logic          f_drain, acc_wr, ev_wr, od_wr;

    assign f_idx   = f_tag[IW-1:0];
    assign f_drain = f_tag[IW];
    assign acc_wr  = f_valid && !f_drain;
    assign ev_wr   = acc_wr && !r_col[0];
    assign od_wr   = acc_wr && r_col[0];

    always_ff @(posedge i_clk) begin
        if (ev_wr) begin
            ev_mem[f_idx] <= f_res;
        end
        if (od_wr) begin
            od_mem[f_idx] <= f_res;
        end
        if (i_cmd.issue) begin
            r_ev_q <= ev_mem[i_idx];
            r_od_q <= od_mem[i_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_ev_vld <= '0;
            r_od_vld <= '0;
        end else begin
            if (ev_wr) begin
                r_ev_vld[f_idx] <= 1'b1;
            end
            if (od_wr) begin
                r_od_vld[f_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_ev_ok    <= r_ev_vld[i_idx];
            r_od_ok    <= r_od_vld[i_idx];
            r_rd_idx   <= i_idx;
            r_rd_drain <= i_cmd.drain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.issue;
        end
    end

    logic [31:0] ev_acc, od_acc, fa, fb, fc;

    assign ev_acc = r_ev_ok ? r_ev_q : 32'd0;
    assign od_acc = r_od_ok ? r_od_q : 32'd0;
    assign fa     = r_rd_drain ? ev_acc : r_val;
    assign fb     = r_rd_drain ? lbd_pkg::FP_ONE : r_wq;
    assign fc     = (r_rd_drain || r_col[0]) ? od_acc : ev_acc;

    lbd_fma #(
        .TW (TW)
    ) u_fma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rd_valid),
        .i_tag   ({r_rd_drain, r_rd_idx}),
        .i_a     (fa),
        .i_b     (fb),
        .i_c     (fc),
        .o_valid (f_valid),
        .o_tag   (f_tag),
        .o_res   (f_res),
        .o_busy  (f_busy)
    );

    logic        r_out_valid, r_out_last;
    logic [5:0]  r_out_feat;
    logic [31:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (f_valid && f_drain) begin
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_valid && f_drain) begin
            r_out_feat <= 6'(f_idx);
            r_out_data <= f_res;
            r_out_last <= ((NW + 1)'(f_idx) + (NW + 1)'(1)) == (NW + 1)'(n);
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {2'd0, r_out_data, r_out_feat};
    assign o_tlast  = r_out_last;

    assign o_sts.in_op     = i_tuser;
    assign o_sts.in_upd_ok = col_ok && (n != '0);
    assign o_sts.in_last   = i_tlast;
    assign o_sts.pipe_busy = r_rd_valid || f_busy;
    assign o_sts.out_full  = r_out_valid;

endmodule

`default_nettype wire

>>> rtl/core/linear_backward_data_matvec.sv
// Channel   Dir  Width  Contents
// s_axis    in   48+1+1 tdata: row, col, value; tuser: op; tlast: last_col
// m_axis    out  40+1   tdata: feature, grad_in; tlast: last
// cfg       in   1+9    index (0 in_dim, 1 out_dim), data
//
// A weight load leaves s_axis ready. A gradient element with a valid column issues one update
// for each of the n features, n = min(in_dim, MAX_IN), then lets the accumulator read stage and
// six FMA stages empty before the next. A row end adds one FMA pass per feature and one clear.
// Reset is synchronous, active low; accumulators read as +0 after reset, weights are unset.
// A waiting result holds m_axis and the next feature; s_axis is taken once the row is cleared.
`default_nettype none

module linear_backward_data_matvec #(
    parameter int MAX_IN  = 64,
    parameter int MAX_OUT = 256
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [lbd_pkg::S_DATA_W-1:0] s_axis_tdata,  // row[5:0] col[13:6] value[45:14]
    input  wire logic                         s_axis_tuser,  // op
    input  wire logic                         s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [lbd_pkg::M_DATA_W-1:0]      m_axis_tdata,  // feature[5:0] grad_in[37:6]
    output logic                              m_axis_tlast,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic                         i_cfg_index,
    input  wire logic [lbd_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int IW = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
    localparam int NW = $clog2(MAX_IN + 1);

    lbd_pkg::t_cmd cmd;
    lbd_pkg::t_sts sts;
    logic [IW-1:0] idx;
    logic [NW-1:0] n;

    lbd_ctrl #(
        .MAX_IN (MAX_IN)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_sts    (sts),
        .i_n      (n),
        .o_cmd    (cmd),
        .o_idx    (idx)
    );

    lbd_datapath #(
        .MAX_IN  (MAX_IN),
        .MAX_OUT (MAX_OUT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_idx       (idx),
        .o_sts       (sts),
        .o_n         (n),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .i_tlast     (s_axis_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tlast     (m_axis_tlast)
    );

endmodule

`default_nettype wire

>>> rtl/core/lbd_checker.sv
`default_nettype none

module lbd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tuser,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);

    logic s_acc;

    assign s_acc = s_axis_tvalid && s_axis_tready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && !s_axis_tuser && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("weight load produced a result");

    a_mid_row_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && s_axis_tuser && !s_axis_tlast && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result before row end");

endmodule

bind linear_backward_data_matvec lbd_checker u_lbd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> bench/tb_linear_backward_data_matvec.sv
`timescale 1ns / 100ps

module tb_linear_backward_data_matvec;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int SETTLE = 800;

    typedef struct packed {
        logic        op;
        logic [5:0]  row;
        logic [7:0]  col;
        logic [31:0] val;
        logic        lastc;
        logic        fixed;
        logic [31:0] fgrad;
    } t_stim;

    typedef struct packed {
        logic [5:0]  feat;
        logic [31:0] grad;
        logic        last;
    } t_grad_res;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [lbd_pkg::S_DATA_W-1:0] s_axis_tdata = '0;  // row, col, value, pad
    logic                         s_axis_tuser = 1'b0;  // op
    logic                         s_axis_tlast = 1'b0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [lbd_pkg::M_DATA_W-1:0] m_axis_tdata;  // feature, grad_in, pad
    logic                         m_axis_tlast;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic                         i_cfg_index = 1'b0;
    logic [lbd_pkg::CFG_W-1:0]    i_cfg_data = '0;

    linear_backward_data_matvec u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    logic [31:0] weights [64][256];
    bit          written [64][256];
    logic [31:0] acc_even [64];
    logic [31:0] acc_odd [64];
    logic [6:0]  cur_in;
    logic [8:0]  cur_out;
    t_grad_res   grad_q [$];
    int          errors = 0;
    int          cycles = 0;
    bit          send_idle = 1'b1;
    bit          sink_idle = 1'b1;
    t_stim       dir_tab [$];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("linear_backward_data_matvec verification failed");
            $finish;
        end
    end

    function automatic real sp_to_real(input logic [31:0] b);
        logic [63:0] d;
        logic [23:0] mm;
        int e2;
        if (b[30:23] == 8'hFF) begin
            d = {b[31], 11'h7FF, b[22:0], 29'b0};
        end else if (b[30:23] == 8'h00) begin
            if (b[22:0] == 0) begin
                d = {b[31], 63'b0};
            end else begin
                mm = {1'b0, b[22:0]};
                e2 = -126;
                while (!mm[23]) begin
                    mm = mm << 1;
                    e2--;
                end
                d = {b[31], 11'(e2 + 1023), mm[22:0], 29'b0};
            end
        end else begin
            d = {b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'b0};
        end
        return $bitstoreal(d);
    endfunction

    function automatic logic [31:0] dbl_to_sp(input logic [63:0] d);
        logic [63:0] m, q, rem, half;
        int e, sh;
        if (d[62:52] == 11'h7FF) begin
            if (d[51:0] != 0) return lbd_pkg::FP_QNAN;
            return {d[63], 8'hFF, 23'b0};
        end
        if (d[62:52] == 0) return {d[63], 31'b0};
        m = {11'b0, 1'b1, d[51:0]};
        e = int'(d[62:52]) - 1023 + 127;
        sh = (e >= 1) ? 29 : 29 + 1 - e;
        if (sh >= 55) return {d[63], 31'b0};
        q = m >> sh;
        rem = m & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) q = q + 1;
        if (e >= 1) begin
            if (q[24]) begin
                q = q >> 1;
                e++;
            end
            if (e >= 255) return {d[63], 8'hFF, 23'b0};
            return {d[63], 8'(e), q[22:0]};
        end
        return {d[63], 31'(q)};
    endfunction

    // single rounding: round-to-odd double sum, then narrow
    function automatic logic [31:0] fused_madd(input logic [31:0] a, input logic [31:0] b,
                                               input logic [31:0] c);
        real p, cc, s, bv, av, err;
        logic [63:0] sb;
        p = sp_to_real(a) * sp_to_real(b);
        cc = sp_to_real(c);
        s = p + cc;
        sb = $realtobits(s);
        if (sb[62:52] != 11'h7FF) begin
            bv = s - p;
            av = s - bv;
            err = (p - av) + (cc - bv);
            if (err != 0.0 && !sb[0]) begin
                if ((s > 0.0) == (err > 0.0)) sb = sb + 1;
                else sb = sb - 1;
            end
        end
        return dbl_to_sp(sb);
    endfunction

    function automatic t_stim mk(input logic op, input logic [5:0] row, input logic [7:0] col,
                                 input logic [31:0] val, input logic lastc,
                                 input logic fixed, input logic [31:0] fgrad);
        return {op, row, col, val, lastc, fixed, fgrad};
    endfunction

    function automatic logic [31:0] rand_fp();
        if ($urandom_range(0, 7) == 0) return $urandom;
        return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
    endfunction

    function automatic int feat_count();
        return (cur_in > 64) ? 64 : int'(cur_in);
    endfunction

    task automatic apply_transaction(input t_stim it);
        int n;
        t_grad_res r;
        n = feat_count();
        if (it.op == lbd_pkg::OP_LOAD) begin
            if (it.col < cur_out) weights[it.row][it.col] = it.val;
            return;
        end
        if (it.col < cur_out) begin
            for (int i = 0; i < n; i++) begin
                if (it.col[0]) acc_odd[i] = fused_madd(it.val, weights[i][it.col], acc_odd[i]);
                else acc_even[i] = fused_madd(it.val, weights[i][it.col], acc_even[i]);
            end
        end
        if (it.lastc) begin
            for (int i = 0; i < n; i++) begin
                r.feat = 6'(i);
                r.grad = it.fixed ? it.fgrad
                                  : fused_madd(acc_even[i], lbd_pkg::FP_ONE, acc_odd[i]);
                r.last = (i + 1 == n);
                grad_q.push_back(r);
            end
            for (int i = 0; i < 64; i++) begin
                acc_even[i] = '0;
                acc_odd[i] = '0;
            end
        end
    endtask

    task automatic send_transaction(input t_stim it);
        if (send_idle && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b0, it.val, it.col, it.row};
        s_axis_tuser <= it.op;
        s_axis_tlast <= it.lastc;
        do @(posedge i_clk); while (!s_axis_tready);
        apply_transaction(it);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (grad_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [lbd_pkg::CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == lbd_pkg::CFG_IN_DIM) cur_in = data[6:0];
        else cur_out = data;
    endtask

    // load any missing weight of this column before it is read
    task automatic fill_column(input logic [7:0] col, inout int cnt);
        for (int i = 0; i < feat_count(); i++) begin
            if (!written[i][col]) begin
                written[i][col] = 1'b1;
                send_transaction(mk(lbd_pkg::OP_LOAD, 6'(i), col, rand_fp(), 1'b0, 1'b0, '0));
                cnt++;
            end
        end
    endtask

    task automatic run_phase(input int span, input bit noise, input int items);
        int cnt, len;
        logic [7:0] col;
        logic [5:0] row;
        cnt = 0;
        while (cnt < items) begin
            if (noise && $urandom_range(0, 4) == 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    row = 6'($urandom);
                    col = 8'($urandom);
                    if (col < cur_out) written[row][col] = 1'b1;
                    send_transaction(mk(lbd_pkg::OP_LOAD, row, col, $urandom, 1'($urandom),
                                        1'b0, '0));
                end else if (cur_out < 256) begin
                    col = 8'($urandom_range(int'(cur_out), 255));
                    send_transaction(mk(lbd_pkg::OP_GRAD, 6'($urandom), col, $urandom,
                                        1'($urandom), 1'b0, '0));
                end
                cnt++;
            end else begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    col = 8'($urandom_range(0, span - 1));
                    fill_column(col, cnt);
                    send_transaction(mk(lbd_pkg::OP_GRAD, 6'($urandom), col, rand_fp(),
                                        k == len - 1, 1'b0, '0));
                    cnt++;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        static int hold = 0;
        if (hold > 0) begin
            hold--;
            m_axis_tready <= 1'b0;
        end else if (sink_idle && $urandom_range(0, 7) == 0) begin
            hold = $urandom_range(1, 10) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_grad_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (grad_q.size() == 0) begin
                $error("unexpected result feature=%0d grad_in=%h", m_axis_tdata[5:0],
                       m_axis_tdata[37:6]);
                errors++;
            end else begin
                want = grad_q.pop_front();
                if (m_axis_tdata[5:0] !== want.feat) begin
                    $error("feature expected %0d actual %0d", want.feat, m_axis_tdata[5:0]);
                    errors++;
                end
                if (m_axis_tdata[37:6] !== want.grad) begin
                    $error("grad_in expected %h actual %h", want.grad, m_axis_tdata[37:6]);
                    errors++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last expected %0b actual %0b", want.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    initial begin
        int in_set [6] = '{9'h185, 64, 0, 127, 1, 7};
        int out_set [6] = '{16, 256, 6, 2, 511, 10};
        int spans [6] = '{16, 3, 6, 2, 256, 10};
        bit noisy [6] = '{1, 0, 1, 1, 1, 1};
        for (int i = 0; i < 64; i++) begin
            acc_even[i] = '0;
            acc_odd[i] = '0;
        end
        cur_in = lbd_pkg::IN_DIM_RST;
        cur_out = lbd_pkg::OUT_DIM_RST;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE) @(posedge i_clk);

        cfg_write(lbd_pkg::CFG_IN_DIM, 9'd2);
        cfg_write(lbd_pkg::CFG_OUT_DIM, 9'd4);
        dir_tab = '{
            mk(lbd_pkg::OP_LOAD, 6'd0, 8'd0, 32'h3F80_0000, 1'b0, 1'b0, '0),
            mk(lbd_pkg::OP_LOAD, 6'd1, 8'd0, 32'h4000_0000, 1'b0, 1'b0, '0),
            mk(lbd_pkg::OP_LOAD, 6'd0, 8'd1, 32'h3F80_0000, 1'b0, 1'b0, '0),
            mk(lbd_pkg::OP_LOAD, 6'd1, 8'd1, 32'hBF80_0000, 1'b0, 1'b0, '0),
            mk(lbd_pkg::OP_LOAD, 6'd0, 8'd2, 32'h0000_0000, 1'b0, 1'b0, '0),
            mk(lbd_pkg::OP_LOAD, 6'd1, 8'd2, 32'h0000_0000, 1'b0, 1'b0, '0),
            mk(lbd_pkg::OP_LOAD, 6'd0, 8'd3, 32'h3F80_0000, 1'b0, 1'b0, '0),
            mk(lbd_pkg::OP_LOAD, 6'd1, 8'd3, 32'h3F80_0000, 1'b0, 1'b0, '0),
            mk(lbd_pkg::OP_LOAD, 6'd63, 8'd255, 32'hFFFF_FFFF, 1'b1, 1'b0, '0),
            mk(lbd_pkg::OP_LOAD, 6'd63, 8'd3, 32'hFFFF_FFFF, 1'b0, 1'b0, '0),
            mk(lbd_pkg::OP_GRAD, 6'd0, 8'd200, 32'h3F80_0000, 1'b1, 1'b1, 32'h0000_0000),
            mk(lbd_pkg::OP_GRAD, 6'd0, 8'd2, 32'h7F80_0000, 1'b1, 1'b1, lbd_pkg::FP_QNAN),
            mk(lbd_pkg::OP_GRAD, 6'd0, 8'd3, 32'h7F80_0000, 1'b1, 1'b1, 32'h7F80_0000),
            mk(lbd_pkg::OP_GRAD, 6'd0, 8'd3, 32'h7F80_0001, 1'b1, 1'b1, lbd_pkg::FP_QNAN),
            mk(lbd_pkg::OP_GRAD, 6'd0, 8'd3, 32'h8000_0000, 1'b1, 1'b1, 32'h0000_0000),
            mk(lbd_pkg::OP_GRAD, 6'd63, 8'd0, 32'h3F80_0000, 1'b0, 1'b0, '0),
            mk(lbd_pkg::OP_GRAD, 6'd0, 8'd1, 32'h4040_0000, 1'b1, 1'b0, '0),
            mk(lbd_pkg::OP_GRAD, 6'd0, 8'd0, 32'h7F7F_FFFF, 1'b0, 1'b0, '0),
            mk(lbd_pkg::OP_GRAD, 6'd0, 8'd0, 32'h7F7F_FFFF, 1'b1, 1'b0, '0),
            mk(lbd_pkg::OP_GRAD, 6'd0, 8'd1, 32'h0000_0001, 1'b1, 1'b0, '0),
            mk(lbd_pkg::OP_GRAD, 6'd0, 8'd2, 32'hFFFF_FFFF, 1'b1, 1'b0, '0)
        };
        foreach (dir_tab[k]) begin
            if (dir_tab[k].op == lbd_pkg::OP_LOAD && dir_tab[k].col < cur_out)
                written[dir_tab[k].row][dir_tab[k].col] = 1'b1;
            send_transaction(dir_tab[k]);
        end
        drain();

        for (int p = 0; p < 6; p++) begin
            if (p == 5) begin
                send_idle = 1'b0;
                sink_idle = 1'b0;
            end
            cfg_write(lbd_pkg::CFG_IN_DIM, 9'(in_set[p]));
            cfg_write(lbd_pkg::CFG_OUT_DIM, 9'(out_set[p]));
            run_phase(spans[p], noisy[p], 60);
            drain();
        end

        if (errors == 0) begin
            $display("linear_backward_data_matvec verification clean");
        end else begin
            $display("linear_backward_data_matvec verification failed");
        end
        $finish;
    end

endmodule
